FILE: hdl/drf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drf_pkg
// Shared types and constants of the dominant resource fairness allocator.
// ----------------------------------------------------------------------------
package drf_pkg;

  localparam int RES_W   = 16;
  localparam int SHARE_W = 17;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_ALLOC = 2'd2;

  localparam logic [SHARE_W-1:0] SHARE_ONE = 17'h10000;

  typedef struct packed {
    logic               done;
    logic [SHARE_W-1:0] ratio;
  } div_res_t;

endpackage
`default_nettype wire

FILE: hdl/drf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module drf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/drf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drf_div
// Bit-serial ratio unit: floor(alloc * 2^16 / cap), saturated at one in Q1.16.
// ----------------------------------------------------------------------------
module drf_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [drf_pkg::RES_W-1:0] alloc,
  input  wire logic [drf_pkg::RES_W-1:0] cap,
  output drf_pkg::div_res_t              res
);

  import drf_pkg::*;

  logic [4:0]       cnt_r;
  logic             done_r;
  logic [RES_W-1:0] rem_r;
  logic [RES_W-1:0] quo_r;
  logic [RES_W-1:0] cap_r;
  logic             zero_r;
  logic             sat_r;
  logic [RES_W:0]   rem_sh;
  logic [RES_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {1'b0, cap_r};
  assign ge      = rem_sh >= {1'b0, cap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 5'd1);
      if (start) begin
        cnt_r <= 5'd16;
      end else if (cnt_r != 5'd0) begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= alloc;
      quo_r  <= '0;
      cap_r  <= cap;
      zero_r <= (alloc == '0);
      sat_r  <= (alloc >= cap);
    end else if (cnt_r != 5'd0) begin
      rem_r <= ge ? rem_sub[RES_W-1:0] : rem_sh[RES_W-1:0];
      quo_r <= {quo_r[RES_W-2:0], ge};
    end
  end

  always_comb begin
    res.done = done_r;
    priority if (zero_r) begin
      res.ratio = '0;
    end else if (sat_r) begin
      res.ratio = SHARE_ONE;
    end else begin
      res.ratio = {1'b0, quo_r};
    end
  end

endmodule
`default_nettype wire

FILE: hdl/drf_two_resource_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drf_two_resource_allocator_unit
// Dominant resource fairness allocator over CPU and memory capacity.
//
//   channel  direction  handshake                 payload
//   in       in         start, busy               func, user_index, demands
//   out      out        out_valid (one cycle)     granted .. mem_in_use
//   cfg      in         psel, penable, pready     cpu/mem capacity
//
// Load, clear and unused codes give their result in the cycle after the transfer.
// A granted allocate runs a share scan of one RAM entry per cycle, a fetch, a fit
// check and sixteen steps of the two serial dividers.
// A refused allocate ends after the fit check.
// Reset is synchronous; allocations read as zero until granted again.
// busy is high while an allocate is in flight; the receiver cannot stall.
// ----------------------------------------------------------------------------
module drf_two_resource_allocator_unit #(
  parameter int NUM_USERS = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_func,
  input  wire logic [1:0]                   in_user_index,
  input  wire logic [drf_pkg::RES_W-1:0]    in_cpu_demand,
  input  wire logic [drf_pkg::RES_W-1:0]    in_mem_demand,
  output logic                              out_valid,
  output logic                              out_granted,
  output logic                              out_refused,
  output logic [1:0]                        out_chosen_user,
  output logic [drf_pkg::SHARE_W-1:0]       out_new_share,
  output logic [drf_pkg::RES_W-1:0]         out_cpu_in_use,
  output logic [drf_pkg::RES_W-1:0]         out_mem_in_use,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  import drf_pkg::*;

  localparam int AW    = $clog2(NUM_USERS);
  localparam int CW    = $clog2(NUM_USERS + 1);
  localparam int IW    = (AW > 2) ? AW : 2;
  localparam int DEM_W = 2 * RES_W;
  localparam int ENT_W = 2 * RES_W + SHARE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_CHECK,
    S_DIV
  } state_t;

  state_t               state_r;
  logic [RES_W-1:0]     cpu_cap_r;
  logic [RES_W-1:0]     mem_cap_r;
  logic [RES_W-1:0]     cpu_used_r;
  logic [RES_W-1:0]     mem_used_r;
  logic [NUM_USERS-1:0] valid_r;
  logic [CW-1:0]        scan_cnt_r;
  logic [AW-1:0]        best_r;
  logic [SHARE_W-1:0]   best_share_r;
  logic [AW-1:0]        raddr_q_r;
  logic [RES_W-1:0]     need_cpu_r;
  logic [RES_W-1:0]     need_mem_r;
  logic [RES_W-1:0]     new_cpu_r;
  logic [RES_W-1:0]     new_mem_r;
  logic                 out_valid_r;
  logic                 granted_r;
  logic                 refused_r;
  logic [1:0]           chosen_r;
  logic [SHARE_W-1:0]   share_r;

  logic                 accept;
  logic                 cfg_wr;
  logic [IW-1:0]        uidx_ext;
  logic [IW-1:0]        best_ext;
  logic                 dem_we;
  logic [DEM_W-1:0]     dem_rdata;
  logic                 ent_we;
  logic [AW-1:0]        ent_raddr;
  logic [ENT_W-1:0]     ent_wdata;
  logic [ENT_W-1:0]     ent_rdata;
  logic [ENT_W-1:0]     entry;
  logic [SHARE_W-1:0]   entry_share;
  logic [RES_W-1:0]     entry_cpu;
  logic [RES_W-1:0]     entry_mem;
  logic [RES_W-1:0]     dem_cpu;
  logic [RES_W-1:0]     dem_mem;
  logic                 fits;
  logic [RES_W-1:0]     sum_cpu;
  logic [RES_W-1:0]     sum_mem;
  logic                 div_start;
  logic [SHARE_W-1:0]   new_share;
  div_res_t             div_cpu_res;
  div_res_t             div_mem_res;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign uidx_ext = IW'(in_user_index);
  assign best_ext = IW'(best_r);
  assign dem_we   = accept && (in_func == FUNC_LOAD) && (32'(in_user_index) < NUM_USERS);

  drf_ram #(
    .WIDTH (DEM_W),
    .DEPTH (NUM_USERS)
  ) u_dem_ram (
    .clk   (clk),
    .we    (dem_we),
    .waddr (uidx_ext[AW-1:0]),
    .wdata ({in_cpu_demand, in_mem_demand}),
    .raddr (best_r),
    .rdata (dem_rdata)
  );

  assign ent_raddr = (state_r == S_SCAN) ? scan_cnt_r[AW-1:0] : best_r;
  assign ent_we    = (state_r == S_DIV) && div_cpu_res.done;
  assign new_share = (div_cpu_res.ratio >= div_mem_res.ratio) ? div_cpu_res.ratio
                                                              : div_mem_res.ratio;
  assign ent_wdata = {new_cpu_r, new_mem_r, new_share};

  drf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_USERS)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (best_r),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // An entry that has not been granted since reset or clear reads as zero.
  assign entry       = valid_r[raddr_q_r] ? ent_rdata : '0;
  assign entry_share = entry[SHARE_W-1:0];
  assign entry_mem   = entry[SHARE_W +: RES_W];
  assign entry_cpu   = entry[SHARE_W+RES_W +: RES_W];
  assign dem_cpu     = dem_rdata[RES_W +: RES_W];
  assign dem_mem     = dem_rdata[RES_W-1:0];

  assign fits = (({1'b0, cpu_used_r} + {1'b0, dem_cpu}) <= {1'b0, cpu_cap_r}) &&
                (({1'b0, mem_used_r} + {1'b0, dem_mem}) <= {1'b0, mem_cap_r});
  assign sum_cpu   = entry_cpu + dem_cpu;
  assign sum_mem   = entry_mem + dem_mem;
  assign div_start = (state_r == S_CHECK) && fits;

  drf_div u_div_cpu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .alloc (sum_cpu),
    .cap   (cpu_cap_r),
    .res   (div_cpu_res)
  );

  drf_div u_div_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .alloc (sum_mem),
    .cap   (mem_cap_r),
    .res   (div_mem_res)
  );

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {16'd0, paddr[2] ? mem_cap_r : cpu_cap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_cap_r <= 16'd9;
      mem_cap_r <= 16'd18;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        mem_cap_r <= pwdata[RES_W-1:0];
      end else begin
        cpu_cap_r <= pwdata[RES_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr_q_r <= ent_raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      cpu_used_r  <= '0;
      mem_used_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_func == FUNC_ALLOC) begin
              state_r    <= S_SCAN;
              scan_cnt_r <= '0;
            end else begin
              out_valid_r <= 1'b1;
              granted_r   <= 1'b0;
              refused_r   <= 1'b0;
              chosen_r    <= 2'd0;
              share_r     <= '0;
              if (in_func == FUNC_CLEAR) begin
                valid_r    <= '0;
                cpu_used_r <= '0;
                mem_used_r <= '0;
              end
            end
          end
        end
        S_SCAN: begin
          scan_cnt_r <= scan_cnt_r + CW'(1);
          if (scan_cnt_r != '0) begin
            if ((scan_cnt_r == CW'(1)) || (entry_share < best_share_r)) begin
              best_r       <= raddr_q_r;
              best_share_r <= entry_share;
            end
          end
          if (scan_cnt_r == CW'(NUM_USERS)) begin
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (fits) begin
            need_cpu_r <= dem_cpu;
            need_mem_r <= dem_mem;
            new_cpu_r  <= sum_cpu;
            new_mem_r  <= sum_mem;
            state_r    <= S_DIV;
          end else begin
            out_valid_r <= 1'b1;
            granted_r   <= 1'b0;
            refused_r   <= 1'b1;
            chosen_r    <= best_ext[1:0];
            share_r     <= best_share_r;
            state_r     <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_cpu_res.done) begin
            out_valid_r     <= 1'b1;
            granted_r       <= 1'b1;
            refused_r       <= 1'b0;
            chosen_r        <= best_ext[1:0];
            share_r         <= new_share;
            valid_r[best_r] <= 1'b1;
            cpu_used_r      <= cpu_used_r + need_cpu_r;
            mem_used_r      <= mem_used_r + need_mem_r;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = granted_r;
  assign out_refused     = refused_r;
  assign out_chosen_user = chosen_r;
  assign out_new_share   = share_r;
  assign out_cpu_in_use  = cpu_used_r;
  assign out_mem_in_use  = mem_used_r;

  a_grant_xor_refuse : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(granted_r && refused_r))
    else $error("Grant and refusal reported in the same transfer.");

  a_div_in_step : assert property (@(posedge clk) disable iff (!rst_n)
    div_cpu_res.done == div_mem_res.done)
    else $error("The two ratio units have lost step.");

  a_usage_in_cap : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && granted_r) |-> (cpu_used_r <= cpu_cap_r && mem_used_r <= mem_cap_r))
    else $error("A grant has pushed usage beyond capacity.");

  a_alloc_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_ALLOC) |=> busy)
    else $error("An allocate transfer did not raise busy.");

  a_result_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("A result was issued while an allocate is still in flight.");

endmodule
`default_nettype wire
